// File: design/hpet_monotonic_clock_unit_defines.svh
// Assertion macros shared by the clock unit
`ifndef HPET_MONOTONIC_CLOCK_UNIT_DEFINES_SVH
`define HPET_MONOTONIC_CLOCK_UNIT_DEFINES_SVH

// check a consequent in the same cycle
`define HMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check a consequent in the following cycle
`define HMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hmc_pkg.sv
`timescale 1ns / 1ps

package hmc_pkg;

  localparam int TIME_W    = 64;
  localparam int TICKS_W   = 64;
  localparam int ID_W      = 4;
  localparam int SEC_W     = 35;
  localparam int NANO_W    = 30;
  localparam int STATUS_W  = 2;
  localparam int PERIOD_W  = 27;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int DIV_W     = 64;
  localparam int DIV_REM_W = 30;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int HI_W      = 45;
  localparam int LO_W      = 20;
  localparam int PROD_HI_W = HI_W + PERIOD_W;
  localparam int PROD_LO_W = LO_W + PERIOD_W;
  localparam int MUL_CNT_W = $clog2(PERIOD_W);

  localparam logic [DIV_REM_W-1:0] FS_PER_NS = DIV_REM_W'(1000000);
  localparam logic [DIV_REM_W-1:0] NS_PER_S  = DIV_REM_W'(1000000000);
  localparam logic [TIME_W-1:0]    STEP_NS   = TIME_W'(1000);

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_REBASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_PERIOD = 2'd2;

  localparam logic REG_PERIOD = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV_TICKS,
    ST_MUL,
    ST_DIV_LO,
    ST_COMBINE,
    ST_APPLY,
    ST_UPDATE,
    ST_SPLIT,
    ST_DIV_OUT,
    ST_FINISH
  } state_t;

  function automatic logic id_valid(input logic [ID_W-1:0] id);
    return id == 4'd0 || id == 4'd1 || id == 4'd4 || id == 4'd5 ||
           id == 4'd6 || id == 4'd7;
  endfunction

endpackage

// File: design/hmc_if.sv
`timescale 1ns / 1ps

interface hmc_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [hmc_pkg::TICKS_W-1:0]  counter_ticks;
  logic [hmc_pkg::ID_W-1:0]     clock_sel;

  modport source (output valid, opcode, counter_ticks, clock_sel, input ready);
  modport sink   (input valid, opcode, counter_ticks, clock_sel, output ready);
endinterface

interface hmc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [hmc_pkg::TIME_W-1:0]   time_ns;
  logic [hmc_pkg::SEC_W-1:0]    seconds;
  logic [hmc_pkg::NANO_W-1:0]   nanoseconds;
  logic [hmc_pkg::STATUS_W-1:0] status;

  modport source (output valid, time_ns, seconds, nanoseconds, status, input ready);
  modport sink   (input valid, time_ns, seconds, nanoseconds, status, output ready);
endinterface

// File: design/hmc_div.sv
`timescale 1ns / 1ps

module hmc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hmc_pkg::DIV_W-1:0]       dividend,
  input  logic [hmc_pkg::DIV_REM_W-1:0]   divisor,
  output logic                            done,
  output logic [hmc_pkg::DIV_W-1:0]       quotient,
  output logic [hmc_pkg::DIV_REM_W-1:0]   remainder
);

  localparam logic [hmc_pkg::DIV_CNT_W-1:0] LAST = hmc_pkg::DIV_CNT_W'(hmc_pkg::DIV_W - 1);

  logic                            busy;
  logic [hmc_pkg::DIV_CNT_W-1:0]   cnt;
  logic [hmc_pkg::DIV_W-1:0]       quo;
  logic [hmc_pkg::DIV_REM_W-1:0]   rem;
  logic [hmc_pkg::DIV_REM_W-1:0]   dvs;
  logic [hmc_pkg::DIV_REM_W:0]     trial;
  logic [hmc_pkg::DIV_REM_W:0]     diff;
  logic                            fits;
  logic [hmc_pkg::DIV_REM_W-1:0]   rem_next;

  always_comb begin
    trial    = {rem, quo[hmc_pkg::DIV_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[hmc_pkg::DIV_REM_W-1:0] : trial[hmc_pkg::DIV_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[hmc_pkg::DIV_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: design/hmc_mul.sv
`timescale 1ns / 1ps

module hmc_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hmc_pkg::HI_W-1:0]        mcand_hi,
  input  logic [hmc_pkg::LO_W-1:0]        mcand_lo,
  input  logic [hmc_pkg::PERIOD_W-1:0]    mplier,
  output logic                            done,
  output logic [hmc_pkg::PROD_HI_W-1:0]   prod_hi,
  output logic [hmc_pkg::PROD_LO_W-1:0]   prod_lo
);

  localparam logic [hmc_pkg::MUL_CNT_W-1:0] LAST =
    hmc_pkg::MUL_CNT_W'(hmc_pkg::PERIOD_W - 1);

  logic                            busy;
  logic [hmc_pkg::MUL_CNT_W-1:0]   cnt;
  logic [hmc_pkg::PERIOD_W-1:0]    bits;
  logic [hmc_pkg::HI_W-1:0]        a_hi;
  logic [hmc_pkg::LO_W-1:0]        a_lo;
  logic [hmc_pkg::PROD_HI_W-1:0]   acc_hi;
  logic [hmc_pkg::PROD_LO_W-1:0]   acc_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // take the multiplier MSB first: double and add
  always_ff @(posedge clk) begin
    if (start) begin
      bits   <= mplier;
      a_hi   <= mcand_hi;
      a_lo   <= mcand_lo;
      acc_hi <= '0;
      acc_lo <= '0;
    end else if (busy) begin
      bits   <= {bits[hmc_pkg::PERIOD_W-2:0], 1'b0};
      acc_hi <= {acc_hi[hmc_pkg::PROD_HI_W-2:0], 1'b0} +
                (bits[hmc_pkg::PERIOD_W-1] ? hmc_pkg::PROD_HI_W'(a_hi) : '0);
      acc_lo <= {acc_lo[hmc_pkg::PROD_LO_W-2:0], 1'b0} +
                (bits[hmc_pkg::PERIOD_W-1] ? hmc_pkg::PROD_LO_W'(a_lo) : '0);
    end
  end

  assign prod_hi = acc_hi;
  assign prod_lo = acc_lo;

endmodule

// File: design/hpet_monotonic_clock_unit.sv
// Work per beat: three 64-step bit-serial divisions and one 27-step shift-add
// multiply for a counter-mode read or a rebase, one division for a stepping
// read, an invalid clock id or an ignored rebase. Requests are taken one at
// a time; the result register frees the unit once the previous beat is taken.
// Reset: rst is synchronous, active high; it clears period, time, offset, mode.
`timescale 1ns / 1ps
`include "hpet_monotonic_clock_unit_defines.svh"

module hpet_monotonic_clock_unit (
  input  logic                           clk,
  input  logic                           rst,
  hmc_req_if.sink                        req,
  hmc_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hmc_pkg::PADDR_W-1:0]    paddr,
  input  logic [hmc_pkg::PDATA_W-1:0]    pwdata,
  output logic [hmc_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  hmc_pkg::state_t state, state_next;

  logic [hmc_pkg::PERIOD_W-1:0]  period;
  logic [hmc_pkg::TIME_W-1:0]    last_time;
  logic [hmc_pkg::TIME_W-1:0]    clock_offset;
  logic                          counter_mode;

  logic                          op;
  logic [hmc_pkg::TICKS_W-1:0]   ticks;
  logic [hmc_pkg::ID_W-1:0]      id;
  logic [hmc_pkg::TIME_W-1:0]    raw;
  logic [hmc_pkg::TIME_W-1:0]    t;
  logic [hmc_pkg::STATUS_W-1:0]  status;

  logic                          rsp_valid;
  logic [hmc_pkg::TIME_W-1:0]    rsp_time;
  logic [hmc_pkg::SEC_W-1:0]     rsp_sec;
  logic [hmc_pkg::NANO_W-1:0]    rsp_nano;
  logic [hmc_pkg::STATUS_W-1:0]  rsp_status;

  logic                          div_start;
  logic [hmc_pkg::DIV_W-1:0]     div_dividend;
  logic [hmc_pkg::DIV_REM_W-1:0] div_divisor;
  logic                          div_done;
  logic [hmc_pkg::DIV_W-1:0]     div_quotient;
  logic [hmc_pkg::DIV_REM_W-1:0] div_remainder;

  logic                          mul_start;
  logic                          mul_done;
  logic [hmc_pkg::PROD_HI_W-1:0] prod_hi;
  logic [hmc_pkg::PROD_LO_W-1:0] prod_lo;

  logic                          is_rebase;
  logic                          period_zero;
  logic                          id_ok;
  logic                          use_counter;
  logic [hmc_pkg::TIME_W-1:0]    stepped;
  logic [hmc_pkg::TIME_W:0]      conv_sum;
  logic [hmc_pkg::TIME_W-1:0]    conv_ns;
  logic [hmc_pkg::TIME_W:0]      off_diff;
  logic [hmc_pkg::TIME_W:0]      cand_sum;
  logic                          out_load;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == hmc_pkg::REG_PERIOD);
  assign prdata    = (paddr[2] == hmc_pkg::REG_PERIOD) ?
                     hmc_pkg::PDATA_W'(period) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
    end else if (cfg_write) begin
      period <= pwdata[hmc_pkg::PERIOD_W-1:0];
    end
  end

  hmc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  hmc_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .mcand_hi (div_quotient[hmc_pkg::HI_W-1:0]),
    .mcand_lo (div_remainder[hmc_pkg::LO_W-1:0]),
    .mplier   (period),
    .done     (mul_done),
    .prod_hi  (prod_hi),
    .prod_lo  (prod_lo)
  );

  always_comb begin
    is_rebase   = op == hmc_pkg::OP_REBASE;
    period_zero = period == '0;
    id_ok       = hmc_pkg::id_valid(id);
    use_counter = counter_mode && !period_zero;
    stepped     = last_time + hmc_pkg::STEP_NS;
    conv_sum    = {1'b0, prod_hi[hmc_pkg::TIME_W-1:0]} +
                  (hmc_pkg::TIME_W + 1)'(div_quotient[hmc_pkg::PERIOD_W-1:0]);
    conv_ns     = ((|prod_hi[hmc_pkg::PROD_HI_W-1:hmc_pkg::TIME_W]) ||
                   conv_sum[hmc_pkg::TIME_W]) ? '1 : conv_sum[hmc_pkg::TIME_W-1:0];
    off_diff    = {1'b0, last_time} - {1'b0, raw};
    cand_sum    = {1'b0, raw} + {1'b0, clock_offset};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hmc_pkg::ST_IDLE:      if (req.valid) state_next = hmc_pkg::ST_DISPATCH;
      hmc_pkg::ST_DISPATCH: begin
        if (is_rebase) begin
          state_next = period_zero ? hmc_pkg::ST_SPLIT : hmc_pkg::ST_DIV_TICKS;
        end else if (id_ok && use_counter) begin
          state_next = hmc_pkg::ST_DIV_TICKS;
        end else begin
          state_next = hmc_pkg::ST_SPLIT;
        end
      end
      hmc_pkg::ST_DIV_TICKS: if (div_done) state_next = hmc_pkg::ST_MUL;
      hmc_pkg::ST_MUL:       if (mul_done) state_next = hmc_pkg::ST_DIV_LO;
      hmc_pkg::ST_DIV_LO:    if (div_done) state_next = hmc_pkg::ST_COMBINE;
      hmc_pkg::ST_COMBINE:   state_next = hmc_pkg::ST_APPLY;
      hmc_pkg::ST_APPLY:     state_next = is_rebase ? hmc_pkg::ST_SPLIT : hmc_pkg::ST_UPDATE;
      hmc_pkg::ST_UPDATE:    state_next = hmc_pkg::ST_SPLIT;
      hmc_pkg::ST_SPLIT:     state_next = hmc_pkg::ST_DIV_OUT;
      hmc_pkg::ST_DIV_OUT:   if (div_done) state_next = hmc_pkg::ST_FINISH;
      hmc_pkg::ST_FINISH:    if (!rsp_valid || rsp.ready) state_next = hmc_pkg::ST_IDLE;
      default:               state_next = hmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = ticks;
    div_divisor  = hmc_pkg::FS_PER_NS;
    mul_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      hmc_pkg::ST_IDLE:      req.ready = 1'b1;
      hmc_pkg::ST_DISPATCH:  div_start = is_rebase ? !period_zero : (id_ok && use_counter);
      hmc_pkg::ST_DIV_TICKS: mul_start = div_done;
      hmc_pkg::ST_MUL: begin
        div_start    = mul_done;
        div_dividend = hmc_pkg::DIV_W'(prod_lo);
      end
      hmc_pkg::ST_SPLIT: begin
        div_start    = 1'b1;
        div_dividend = t;
        div_divisor  = hmc_pkg::NS_PER_S;
      end
      hmc_pkg::ST_FINISH:    out_load = !rsp_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hmc_pkg::ST_IDLE;
      last_time    <= '0;
      clock_offset <= '0;
      counter_mode <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == hmc_pkg::ST_DISPATCH && !is_rebase && id_ok && !use_counter) begin
        last_time <= stepped;
      end
      if (state == hmc_pkg::ST_APPLY && is_rebase) begin
        clock_offset <= off_diff[hmc_pkg::TIME_W] ? '0 : off_diff[hmc_pkg::TIME_W-1:0];
        counter_mode <= 1'b1;
      end
      if (state == hmc_pkg::ST_UPDATE && raw > last_time) begin
        last_time <= raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == hmc_pkg::ST_IDLE && req.valid) begin
      op    <= req.opcode;
      ticks <= req.counter_ticks;
      id    <= req.clock_sel;
    end
    if (state == hmc_pkg::ST_DISPATCH) begin
      t <= (!is_rebase && id_ok && !use_counter) ? stepped : '0;
      if (is_rebase && period_zero) begin
        status <= hmc_pkg::STATUS_NO_PERIOD;
      end else if (!is_rebase && !id_ok) begin
        status <= hmc_pkg::STATUS_BAD_ID;
      end else begin
        status <= hmc_pkg::STATUS_OK;
      end
    end
    if (state == hmc_pkg::ST_COMBINE) begin
      raw <= conv_ns;
    end
    // saturate offset plus converted time
    if (state == hmc_pkg::ST_APPLY && !is_rebase) begin
      raw <= cand_sum[hmc_pkg::TIME_W] ? '1 : cand_sum[hmc_pkg::TIME_W-1:0];
    end
    if (state == hmc_pkg::ST_UPDATE) begin
      t <= (raw > last_time) ? raw : last_time;
    end
    if (out_load) begin
      rsp_time   <= t;
      rsp_sec    <= div_quotient[hmc_pkg::SEC_W-1:0];
      rsp_nano   <= div_remainder[hmc_pkg::NANO_W-1:0];
      rsp_status <= status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.time_ns     = rsp_time;
  assign rsp.seconds     = rsp_sec;
  assign rsp.nanoseconds = rsp_nano;
  assign rsp.status      = rsp_status;

  `HMC_ASSERT_NEXT(a_time_monotonic, state == hmc_pkg::ST_UPDATE, last_time >= $past(last_time), "published time stepped back")
  `HMC_ASSERT_NEXT(a_rebase_sets_mode, state == hmc_pkg::ST_APPLY && is_rebase, counter_mode, "rebase left stepping mode")
  `HMC_ASSERT_SAME(a_error_zero_time, rsp_valid && rsp_status != hmc_pkg::STATUS_OK, rsp_time == '0, "non-ok beat carries a time")
  `HMC_ASSERT_SAME(a_no_start_clash, div_start, !mul_start, "divider and multiplier started together")

endmodule

// File: dv/hpet_monotonic_clock_unit_tb.sv
`timescale 1ns / 1ps

module hpet_monotonic_clock_unit_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [hmc_pkg::TIME_W-1:0] TIME_MAX = {hmc_pkg::TIME_W{1'b1}};
  localparam logic [hmc_pkg::TICKS_W-1:0] TICKS_MAX = {hmc_pkg::TICKS_W{1'b1}};
  localparam logic [hmc_pkg::PADDR_W-1:0] PERIOD_ADDR =
    hmc_pkg::PADDR_W'(4 * int'(hmc_pkg::REG_PERIOD));
  localparam logic [hmc_pkg::PERIOD_W-1:0] PERIOD_TOP = hmc_pkg::PERIOD_W'(100000000);

  typedef struct packed {
    logic [hmc_pkg::TIME_W-1:0]   time_ns;
    logic [hmc_pkg::SEC_W-1:0]    seconds;
    logic [hmc_pkg::NANO_W-1:0]   nanoseconds;
    logic [hmc_pkg::STATUS_W-1:0] status;
  } clock_reading_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [hmc_pkg::PERIOD_W-1:0] period;
    logic                         op;
    logic [hmc_pkg::TICKS_W-1:0]  ticks;
    logic [hmc_pkg::ID_W-1:0]     id;
    logic                         typed;
    logic [hmc_pkg::TIME_W-1:0]   time_ns;
    logic [hmc_pkg::STATUS_W-1:0] status;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [hmc_pkg::PADDR_W-1:0] paddr;
  logic [hmc_pkg::PDATA_W-1:0] pwdata, prdata;

  logic                         typed_now;
  logic [hmc_pkg::TIME_W-1:0]   typed_time;
  logic [hmc_pkg::STATUS_W-1:0] typed_status;

  hmc_req_if req_ch ();
  hmc_rsp_if rsp_ch ();

  hpet_monotonic_clock_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  logic [hmc_pkg::PERIOD_W-1:0] period_cfg = '0;
  logic [hmc_pkg::TIME_W-1:0]   last_ns = '0;
  logic [hmc_pkg::TIME_W-1:0]   offset_ns = '0;
  logic                         counter_on = 1'b0;

  clock_reading_t readings_due[$];
  plan_row_t      plan_q[$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  int             beats_sent = 0;
  bit             quiet = 1'b0;

  function automatic logic [hmc_pkg::TIME_W-1:0] ticks_to_ns(
      input logic [hmc_pkg::TICKS_W-1:0] ticks,
      input logic [hmc_pkg::PERIOD_W-1:0] per);
    logic [hmc_pkg::TICKS_W-1:0] whole, frac;
    logic [127:0]                hi_prod;
    logic [hmc_pkg::TIME_W-1:0]  lo_ns;
    logic [hmc_pkg::TIME_W:0]    sum;
    if (per == '0) return '0;
    whole = ticks / 64'(hmc_pkg::FS_PER_NS);
    frac = ticks % 64'(hmc_pkg::FS_PER_NS);
    hi_prod = 128'(whole) * 128'(per);
    if (hi_prod[127:64] != '0) return TIME_MAX;
    lo_ns = (frac * 64'(per)) / 64'(hmc_pkg::FS_PER_NS);
    sum = {1'b0, hi_prod[63:0]} + {1'b0, lo_ns};
    if (sum[hmc_pkg::TIME_W]) return TIME_MAX;
    return sum[hmc_pkg::TIME_W-1:0];
  endfunction

  function automatic clock_reading_t split_time(input logic [hmc_pkg::TIME_W-1:0] t,
                                                input logic [hmc_pkg::STATUS_W-1:0] st);
    clock_reading_t r;
    r.time_ns = t;
    r.seconds = hmc_pkg::SEC_W'(t / 64'(hmc_pkg::NS_PER_S));
    r.nanoseconds = hmc_pkg::NANO_W'(t % 64'(hmc_pkg::NS_PER_S));
    r.status = st;
    return r;
  endfunction

  function automatic bit clock_sel_ok(input logic [hmc_pkg::ID_W-1:0] id);
    return id == 4'd0 || id == 4'd1 || (id >= 4'd4 && id <= 4'd7);
  endfunction

  function automatic clock_reading_t advance_clock(
      input logic op,
      input logic [hmc_pkg::TICKS_W-1:0] ticks,
      input logic [hmc_pkg::ID_W-1:0] id);
    logic [hmc_pkg::TIME_W-1:0] raw;
    logic [hmc_pkg::TIME_W:0]   cand;
    if (op == hmc_pkg::OP_REBASE) begin
      if (period_cfg == '0) return split_time('0, hmc_pkg::STATUS_NO_PERIOD);
      raw = ticks_to_ns(ticks, period_cfg);
      offset_ns = (last_ns > raw) ? last_ns - raw : '0;
      counter_on = 1'b1;
      return split_time('0, hmc_pkg::STATUS_OK);
    end
    if (!clock_sel_ok(id)) return split_time('0, hmc_pkg::STATUS_BAD_ID);
    if (counter_on && period_cfg != '0) begin
      raw = ticks_to_ns(ticks, period_cfg);
      cand = {1'b0, raw} + {1'b0, offset_ns};
      if (cand[hmc_pkg::TIME_W]) cand = {1'b0, TIME_MAX};
      if (cand[hmc_pkg::TIME_W-1:0] > last_ns) last_ns = cand[hmc_pkg::TIME_W-1:0];
    end else begin
      last_ns = last_ns + hmc_pkg::STEP_NS;
    end
    return split_time(last_ns, hmc_pkg::STATUS_OK);
  endfunction

  always @(posedge clk) begin : scoreboard
    clock_reading_t got, want;
    bit busy;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      busy = 1'b0;
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        if (paddr == PERIOD_ADDR) period_cfg = pwdata[hmc_pkg::PERIOD_W-1:0];
      end
      if (req_ch.valid && req_ch.ready) begin
        busy = 1'b1;
        want = advance_clock(req_ch.opcode, req_ch.counter_ticks, req_ch.clock_sel);
        if (typed_now) want = split_time(typed_time, typed_status);
        readings_due.push_back(want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        busy = 1'b1;
        got = {rsp_ch.time_ns, rsp_ch.seconds, rsp_ch.nanoseconds, rsp_ch.status};
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: time %0d sec %0d ns %0d status %0d",
                     got.time_ns, got.seconds, got.nanoseconds, got.status);
        end else begin
          want = readings_due.pop_front();
          if (got.time_ns !== want.time_ns || got.seconds !== want.seconds ||
              got.nanoseconds !== want.nanoseconds || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp time %0d sec %0d ns %0d st %0d, got %0d %0d %0d %0d",
                       want.time_ns, want.seconds, want.nanoseconds, want.status,
                       got.time_ns, got.seconds, got.nanoseconds, got.status);
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : int'($urandom_range(0, 17));
  endfunction

  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic send_item(input logic op, input logic [hmc_pkg::TICKS_W-1:0] ticks,
                           input logic [hmc_pkg::ID_W-1:0] id, input logic typed,
                           input logic [hmc_pkg::TIME_W-1:0] t,
                           input logic [hmc_pkg::STATUS_W-1:0] st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.counter_ticks <= ticks;
    req_ch.clock_sel <= id;
    typed_now <= typed;
    typed_time <= t;
    typed_status <= st;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [hmc_pkg::PERIOD_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PERIOD_ADDR;
    pwdata <= hmc_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [hmc_pkg::PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return hmc_pkg::PERIOD_W'(1);
      3: return PERIOD_TOP;
      4: return hmc_pkg::PERIOD_W'($urandom_range(1, 1000));
      default: return hmc_pkg::PERIOD_W'($urandom_range(10000000, 100000000));
    endcase
  endfunction

  initial begin
    logic [hmc_pkg::TICKS_W-1:0] tick_now;
    logic [hmc_pkg::TICKS_W-1:0] ticks;
    logic [hmc_pkg::ID_W-1:0]    id;
    logic                        op;
    int                          v;
    int                          phase_len;

    req_ch.valid = 1'b0;
    req_ch.opcode = hmc_pkg::OP_READ;
    req_ch.counter_ticks = '0;
    req_ch.clock_sel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    typed_now = 1'b0;
    typed_time = '0;
    typed_status = hmc_pkg::STATUS_OK;

    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd0, 1'b1, 64'd1000,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, TICKS_MAX, 4'd7, 1'b1, 64'd2000,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd2, 1'b1, 64'd0,
                       hmc_pkg::STATUS_BAD_ID});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, TICKS_MAX, 4'd15, 1'b1, 64'd0,
                       hmc_pkg::STATUS_BAD_ID});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd3, 1'b1, 64'd0,
                       hmc_pkg::STATUS_BAD_ID});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, 64'd12345, 4'd0, 1'b1, 64'd0,
                       hmc_pkg::STATUS_NO_PERIOD});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd1, 1'b1, 64'd3000,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_CFG, PERIOD_TOP, hmc_pkg::OP_READ, '0, '0, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, 64'd0, 4'd0, 1'b1, 64'd0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd1000000, 4'd4, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd5, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, TICKS_MAX, 4'd6, 1'b1, TIME_MAX,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, 64'd5, 4'd15, 1'b1, 64'd0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd1000000, 4'd0, 1'b1, TIME_MAX,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd1000000, 4'd8, 1'b1, 64'd0,
                       hmc_pkg::STATUS_BAD_ID});
    plan_q.push_back('{ROW_CFG, '0, hmc_pkg::OP_READ, '0, '0, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd0, 4'd1, 1'b1, 64'd999,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, TICKS_MAX, 4'd0, 1'b1, 64'd0,
                       hmc_pkg::STATUS_NO_PERIOD});
    plan_q.push_back('{ROW_CFG, hmc_pkg::PERIOD_W'(1), hmc_pkg::OP_READ, '0, '0, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, 64'd999999, 4'd0, 1'b1, 64'd0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'd1999999, 4'd0, 1'b0, '0,
                       hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'h8000_0000_0000_0000, 4'd7,
                       1'b0, '0, hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_REBASE, 64'h8000_0000_0000_1234, 4'd9,
                       1'b0, '0, hmc_pkg::STATUS_OK});
    plan_q.push_back('{ROW_ITEM, '0, hmc_pkg::OP_READ, 64'hFFFF_FFFF_0000_0000, 4'd6,
                       1'b0, '0, hmc_pkg::STATUS_OK});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        settle();
        write_period(plan_q[i].period);
      end else begin
        send_item(plan_q[i].op, plan_q[i].ticks, plan_q[i].id, plan_q[i].typed,
                  plan_q[i].time_ns, plan_q[i].status);
      end
    end

    tick_now = {32'd0, $urandom};
    beats_sent = 0;
    while (beats_sent < RANDOM_ITEMS) begin
      settle();
      write_period(pick_period());
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 15) == 0)
          tick_now = tick_now - 64'($urandom_range(0, 1 << 16));
        else
          tick_now = tick_now + 64'($urandom_range(0, 1 << 24));
        ticks = tick_now;
        op = hmc_pkg::OP_READ;
        v = $urandom_range(0, 19);
        if (v < 14) begin
          v = $urandom_range(0, 5);
          id = hmc_pkg::ID_W'(v < 2 ? v : v + 2);
        end else if (v < 16) begin
          op = hmc_pkg::OP_REBASE;
          id = hmc_pkg::ID_W'($urandom_range(0, 15));
        end else if (v < 18) begin
          v = $urandom_range(0, 9);
          id = hmc_pkg::ID_W'(v < 2 ? v + 2 : v + 6);
        end else begin
          op = $urandom_range(0, 1) ? hmc_pkg::OP_REBASE : hmc_pkg::OP_READ;
          id = hmc_pkg::ID_W'($urandom_range(0, 15));
          ticks = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 1 << 20));
        end
        send_item(op, ticks, id, 1'b0, '0, hmc_pkg::STATUS_OK);
        if ($urandom_range(0, 63) == 0) settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
